// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the stop-line sequencer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ISS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ISS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- rtl/core/isseq_pkg.sv -----
// Shared types and constants of the intersection stop sequencer.
// No dependencies; imported by every module of the block.
package isseq_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SIGHT = 2'd1;
    localparam logic [1:0] OP_ODO   = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_STOP_DISTANCE = 2'd0;
    localparam logic [1:0] REG_STANDING_TICKS = 2'd1;
    localparam logic [1:0] REG_PASS_DISTANCE = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] STOP_DISTANCE_RESET  = 16'd400;
    localparam logic [15:0] STANDING_TICKS_RESET = 16'd300;
    localparam logic [15:0] PASS_DISTANCE_RESET  = 16'd2000;

    // Configuration as seen by the sequencer core.
    typedef struct packed {
        logic [15:0] stop_distance_mm;
        logic [15:0] standing_ticks;
        logic [15:0] pass_distance_mm;
    } cfg_t;

    // One request held in the input register.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value_mm;
    } item_t;

endpackage

// ----- rtl/core/isseq_cfg.sv -----
// APB-style configuration registers of the intersection stop sequencer.
// Depends on isseq_pkg for register indexes, reset values and cfg_t.
module isseq_cfg
    import isseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] stop_distance_reg;
    logic [15:0] standing_ticks_reg;
    logic [15:0] pass_distance_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes in the access phase; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_distance_reg  <= STOP_DISTANCE_RESET;
            standing_ticks_reg <= STANDING_TICKS_RESET;
            pass_distance_reg  <= PASS_DISTANCE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_STOP_DISTANCE:  stop_distance_reg  <= pwdata[15:0];
                REG_STANDING_TICKS: standing_ticks_reg <= pwdata[15:0];
                REG_PASS_DISTANCE:  pass_distance_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_index)
            REG_STOP_DISTANCE:  prdata = {16'd0, stop_distance_reg};
            REG_STANDING_TICKS: prdata = {16'd0, standing_ticks_reg};
            REG_PASS_DISTANCE:  prdata = {16'd0, pass_distance_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.stop_distance_mm = stop_distance_reg;
    assign cfg.standing_ticks   = standing_ticks_reg;
    assign cfg.pass_distance_mm = pass_distance_reg;

endmodule

// ----- rtl/core/isseq_core.sv -----
// Sequencer core: mode state machine, position state and result register.
// Depends on isseq_pkg and on assert_macros.svh for its assertions.
`include "assert_macros.svh"

module isseq_core
    import isseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       stop,
    output logic [1:0] mode
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_STAND = 2'd2,
        MODE_PASS  = 2'd3
    } mode_t;

    mode_t              state_reg, state_next;
    logic signed [31:0] odo_reg, odo_next;
    logic signed [31:0] line_reg, line_next;
    logic signed [31:0] odo_at_reg, odo_at_next;
    logic        [15:0] count_reg, count_next;
    logic signed [31:0] pass_end_reg, pass_end_next;
    logic               out_valid_reg, out_valid_next;
    logic               stop_reg, stop_next;
    logic        [1:0]  mode_reg, mode_next;

    logic               is_tick;
    logic               item_fire;
    logic signed [33:0] remaining;
    logic signed [32:0] pass_sum;
    logic signed [31:0] pass_end_sat;

    // A tick needs room in the result register; other requests pass freely.
    assign is_tick    = (item.operation == OP_TICK);
    assign item_ready = !is_tick || !out_valid_reg || out_ready;
    assign item_fire  = item_valid && item_ready;

    // Remaining distance to the line, exact in 34 bits.
    assign remaining = {{2{line_reg[31]}}, line_reg}
                     - {{2{odo_reg[31]}}, odo_reg}
                     + {{2{odo_at_reg[31]}}, odo_at_reg};

    // End of the passing stretch, saturated at the largest positive position.
    assign pass_sum     = {odo_reg[31], odo_reg} + {17'd0, cfg.pass_distance_mm};
    assign pass_end_sat = (!pass_sum[32] && pass_sum[31]) ? 32'sh7FFF_FFFF
                                                          : pass_sum[31:0];

    // Next state and result for the request leaving the input register.
    always_comb
    begin
        state_next     = state_reg;
        odo_next       = odo_reg;
        line_next      = line_reg;
        odo_at_next    = odo_at_reg;
        count_next     = count_reg;
        pass_end_next  = pass_end_reg;
        out_valid_next = out_valid_reg && !out_ready;
        stop_next      = stop_reg;
        mode_next      = mode_reg;

        if (item_fire)
        begin
            unique case (item.operation)
                OP_SIGHT:
                begin
                    if (state_reg == MODE_IDLE || state_reg == MODE_LINE)
                    begin
                        line_next   = item.value_mm;
                        odo_at_next = odo_reg;
                        state_next  = MODE_LINE;
                    end
                end
                OP_ODO:
                begin
                    odo_next = item.value_mm;
                end
                OP_TICK:
                begin
                    stop_next = 1'b0;
                    unique case (state_reg)
                        MODE_LINE:
                        begin
                            if (remaining < $signed({18'd0, cfg.stop_distance_mm}))
                            begin
                                state_next = MODE_STAND;
                                count_next = 16'd0;
                            end
                        end
                        MODE_STAND:
                        begin
                            if (count_reg < cfg.standing_ticks)
                            begin
                                stop_next  = 1'b1;
                                count_next = count_reg + 16'd1;
                            end
                            else
                            begin
                                pass_end_next = pass_end_sat;
                                state_next    = MODE_PASS;
                            end
                        end
                        MODE_PASS:
                        begin
                            if (odo_reg > pass_end_reg)
                            begin
                                state_next = MODE_IDLE;
                            end
                        end
                        MODE_IDLE: ;
                    endcase
                    out_valid_next = 1'b1;
                    mode_next      = state_next;
                end
                default: ;
            endcase
        end
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= MODE_IDLE;
            odo_reg       <= '0;
            line_reg      <= '0;
            odo_at_reg    <= '0;
            count_reg     <= '0;
            pass_end_reg  <= '0;
            out_valid_reg <= 1'b0;
            stop_reg      <= 1'b0;
            mode_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            odo_reg       <= odo_next;
            line_reg      <= line_next;
            odo_at_reg    <= odo_at_next;
            count_reg     <= count_next;
            pass_end_reg  <= pass_end_next;
            out_valid_reg <= out_valid_next;
            stop_reg      <= stop_next;
            mode_reg      <= mode_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign stop      = stop_reg;
    assign mode      = mode_reg;

    // Stop is only ever requested while standing.
    `ISS_ASSERT_NEVER(a_stop_only_standing, clk, rst_n,
        out_valid_reg && stop_reg && (mode_reg != MODE_STAND),
        "stop result outside standing mode")

    // Every accepted tick leaves a result in the result register.
    `ISS_ASSERT_CLK(a_tick_gives_result, clk, rst_n,
        (item_fire && is_tick) |=> out_valid_reg,
        "accepted tick produced no result")

    // Other requests never create a result of their own.
    `ISS_ASSERT_CLK(a_no_result_without_tick, clk, rst_n,
        (item_fire && !is_tick && (!out_valid_reg || out_ready)) |=> !out_valid_reg,
        "result produced by a non-tick request")

    // From idle the only way forward is a sighting into line ahead.
    `ISS_ASSERT_CLK(a_idle_exit, clk, rst_n,
        (state_reg == MODE_IDLE) |=> (state_reg == MODE_IDLE || state_reg == MODE_LINE),
        "illegal transition out of idle")

endmodule

// ----- rtl/core/intersection_stop_sequencer.sv -----
// Top level of the intersection stop sequencer: input register, core, config.
// Depends on isseq_pkg, isseq_cfg and isseq_core.

// The sequencer takes one request per clock cycle: a tick, a stop-line
// sighting or an odometer update. A request is first held in the input
// register and is then applied to the mode state, and a tick's result is
// written into the result register when the core accepts the tick; only
// ticks give a result. The sustained rate is one request per cycle; it
// drops only when a tick reaches the core while the previous result still
// waits in the result register, because the single result register then
// holds the tick back. Sightings and odometer updates keep flowing while a
// result waits. Configuration is written through the APB-style port while
// no request is in flight: a rule for the user, the block does not enforce it.
module intersection_stop_sequencer
    import isseq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value_mm,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               stop,
    output logic [1:0]         mode,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg;
    logic  core_ready;

    // Input register: loads whenever it is empty or its request moves on.
    assign in_ready = !item_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.operation <= operation;
            item_reg.value_mm  <= value_mm;
        end
    end

    isseq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isseq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .item_ready (core_ready),
        .item       (item_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stop       (stop),
        .mode       (mode)
    );

endmodule
